FILE: hw/rtl/dcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_pkg - shared constants, types and helpers
// Sizes, register indexes, pipeline tag and arithmetic helpers for the
// differential conjugate product block.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int FIELD_W   = 16;                 // width of one input field
  localparam int OUT_W     = 32;                 // width of one result part
  localparam int LEN_W     = 7;                  // frame_length register
  localparam int LAG_W     = 6;                  // lag register
  localparam int CNT_W     = 7;                  // load count, frame length
  localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int WORD_W    = 2 * SAMPLE_BITS;    // store word {im, re}
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int SUM_W     = PROD_W + 1;
  localparam int BIT_IDX_W = $clog2(LAG_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG          = 2'd1;

  localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = 7'd64;
  localparam logic [LAG_W-1:0] LAG_RST          = 6'd1;

  // Tag that travels alongside a request through the product pipeline
  typedef struct packed {
    logic valid;
    logic zero;   // middle result of an odd frame
    logic last;   // last result of the frame
  } dcp_tag_t;

  // Take the low SAMPLE_BITS bits of a field (zero-filled above the field)
  function automatic logic signed [SAMPLE_BITS-1:0] sample_of(input logic [FIELD_W-1:0] f);
    logic [31:0] z;
    z = 32'(f);
    return z[SAMPLE_BITS-1:0];
  endfunction

  // Clamp a signed sum to the signed 32-bit result range
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [63:0] w;
    logic signed [63:0] w_sat;
    w = 64'(v);
    if (w > 64'sd2147483647) begin
      w_sat = 64'sd2147483647;
    end else if (w < -64'sd2147483648) begin
      w_sat = -64'sd2147483648;
    end else begin
      w_sat = w;
    end
    return w_sat[OUT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/dcp_sample_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_sample_ram - frame sample store
// One write port, two read ports with registered data and a shared enable.
// ----------------------------------------------------------------------------
module dcp_sample_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [dcp_pkg::ADDR_W-1:0] wr_addr,
  input  logic [dcp_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [dcp_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [dcp_pkg::ADDR_W-1:0] rd_addr_b,
  output logic [dcp_pkg::WORD_W-1:0] rd_data_a,
  output logic [dcp_pkg::WORD_W-1:0] rd_data_b
);

  logic [dcp_pkg::WORD_W-1:0] mem_q [dcp_pkg::MAX_FRAME];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // hold read data while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem_q[rd_addr_a];
      rd_data_b <= mem_q[rd_addr_b];
    end
  end

endmodule

FILE: hw/rtl/dcp_lag_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_lag_mod - lag modulo half-length
// Restoring remainder, one dividend bit per cycle; done pulses when ready.
// ----------------------------------------------------------------------------
module dcp_lag_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dcp_pkg::LAG_W-1:0] dividend,
  input  logic [dcp_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [dcp_pkg::CNT_W-1:0] remainder
);

  logic                          busy_r;
  logic                          done_r;
  logic [dcp_pkg::BIT_IDX_W-1:0] bit_r;
  logic [dcp_pkg::LAG_W-1:0]     dvd_r;
  logic [dcp_pkg::CNT_W-1:0]     div_r;
  logic [dcp_pkg::CNT_W-1:0]     rem_r;
  logic [dcp_pkg::CNT_W-1:0]     trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r[dcp_pkg::CNT_W-2:0], dvd_r[bit_r]};
    if (trial >= div_r) begin
      trial = trial - div_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      bit_r <= dcp_pkg::BIT_IDX_W'(dcp_pkg::LAG_W - 1);
    end else if (busy_r) begin
      rem_r <= trial;
      bit_r <= bit_r - 1'b1;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/dcp_cmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_cmul - conjugate product pipeline
// Registered partial products, then sum, saturate and the output register.
// ----------------------------------------------------------------------------
module dcp_cmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  dcp_pkg::dcp_tag_t          tag_in,
  input  logic [dcp_pkg::WORD_W-1:0] word_a,   // x[j]
  input  logic [dcp_pkg::WORD_W-1:0] word_b,   // x[i], conjugated
  output logic                       res_valid,
  output logic [dcp_pkg::OUT_W-1:0]  res_re,
  output logic [dcp_pkg::OUT_W-1:0]  res_im,
  output logic                       res_last
);

  localparam int SB = dcp_pkg::SAMPLE_BITS;

  logic signed [SB-1:0] ar, ai, br, bi;
  logic signed [dcp_pkg::PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  dcp_pkg::dcp_tag_t tag_r;
  logic signed [dcp_pkg::SUM_W-1:0] sum_re, sum_im;
  logic                             valid_r;
  logic [dcp_pkg::OUT_W-1:0]        re_r, im_r;
  logic                             last_r;

  assign ar = word_a[SB-1:0];
  assign ai = word_a[2*SB-1:SB];
  assign br = word_b[SB-1:0];
  assign bi = word_b[2*SB-1:SB];

  always_ff @(posedge clk) begin
    if (advance) begin
      p_rr_r <= ar * br;
      p_ii_r <= ai * bi;
      p_ir_r <= ai * br;
      p_ri_r <= ar * bi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      valid_r <= 1'b0;
    end else if (advance) begin
      tag_r   <= tag_in;
      valid_r <= tag_r.valid;
    end
  end

  assign sum_re = dcp_pkg::SUM_W'(p_rr_r) + dcp_pkg::SUM_W'(p_ii_r);
  assign sum_im = dcp_pkg::SUM_W'(p_ir_r) - dcp_pkg::SUM_W'(p_ri_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      re_r   <= tag_r.zero ? '0 : dcp_pkg::sat_out(sum_re);
      im_r   <= tag_r.zero ? '0 : dcp_pkg::sat_out(sum_im);
      last_r <= tag_r.last;
    end
  end

  assign res_valid = valid_r;
  assign res_re    = re_r;
  assign res_im    = im_r;
  assign res_last  = last_r;

endmodule

FILE: hw/rtl/differential_conj_product_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_conj_product_core - frame differential conjugate product
// Loads a frame of complex samples, then streams its lagged conjugate products.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one complex Q1.15 sample per request. in_tready is high while the
//           block is loading; it takes a sample each cycle in_tvalid is high.
//   out_* : one result per request, {prod_im, prod_re} in Q2.30 with
//           saturation, tlast on the last result of a frame.
//   cfg_* : register writes (frame_length, lag), always accepted; write them
//           only while no frame is loading or emitting.
// Timing: after the last sample of a frame, the bit-serial remainder unit
//   finds the lag remainder, then one result issues per cycle while the
//   output is not stalled, into a three-stage pipeline (store read, partial
//   products, sum and saturate). Loading, remainder and result issue run in
//   turn, with a single store read phase per frame.
//   Loading of the next frame starts as soon as the last result is issued.
// Stall: a held result with out_tready low freezes the whole pipeline and the
//   issue counter; the result stays on out_tdata until taken. No result is lost.
// Reset: synchronous, rst_n low; registers return to frame_length 64, lag 1,
//   load count zero. The store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module differential_conj_product_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample request: [15:0] sample_re, [31:16] sample_im
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,
  // result request: [31:0] prod_re, [63:32] prod_im; tlast is frame_end
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [63:0]                  out_tdata,
  output logic                         out_tlast,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcp_pkg::LEN_W-1:0]    cfg_data
);

  localparam int CW = dcp_pkg::CNT_W;
  localparam int SB = dcp_pkg::SAMPLE_BITS;

  typedef enum logic [1:0] {ST_LOAD, ST_MOD, ST_EMIT} state_t;

  // Configuration registers
  logic [dcp_pkg::LEN_W-1:0] len_r;
  logic [dcp_pkg::LAG_W-1:0] lag_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= dcp_pkg::FRAME_LENGTH_RST;
      lag_r <= dcp_pkg::LAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == dcp_pkg::CFG_FRAME_LENGTH) begin
        len_r <= cfg_data;
      end else if (cfg_index == dcp_pkg::CFG_LAG) begin
        lag_r <= cfg_data[dcp_pkg::LAG_W-1:0];
      end
    end
  end

  // Sequencer state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;     // samples loaded so far
  logic [CW-1:0]    k_r, k_nxt;         // result position being issued
  logic [CW-1:0]    n_r, n_nxt;         // frame length of the frame in flight
  logic [CW-1:0]    half_r, half_nxt;
  logic             mag_r, mag_nxt;     // squared-magnitude mode
  logic [CW-1:0]    dm_r, dm_nxt;       // lag mod half

  logic             in_acc;
  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    cnt_inc;
  logic             frame_done;
  logic             advance;
  logic             issue;
  logic             mod_done;
  logic [CW-1:0]    mod_rem;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;

  // clamp the programmed length to the supported range
  always_comb begin
    if (len_r < CW'(2)) begin
      n_eff = CW'(2);
    end else if (len_r > CW'(dcp_pkg::MAX_FRAME)) begin
      n_eff = CW'(dcp_pkg::MAX_FRAME);
    end else begin
      n_eff = len_r;
    end
  end

  assign cnt_inc    = cnt_r + 1'b1;
  assign frame_done = in_acc && (cnt_inc >= n_eff);

  // the whole pipeline moves when the output register is free or being taken
  assign advance = !out_tvalid || out_tready;
  assign issue   = (state_r == ST_EMIT) && advance;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    half_nxt  = half_r;
    mag_nxt   = mag_r;
    dm_nxt    = dm_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          cnt_nxt = cnt_inc;
        end
        if (frame_done) begin
          cnt_nxt   = '0;
          n_nxt     = n_eff;
          half_nxt  = n_eff >> 1;
          mag_nxt   = (lag_r == '0);
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          dm_nxt    = mod_rem;
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          if (k_r == n_r - 1'b1) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      k_r     <= '0;
      n_r     <= '0;
      half_r  <= '0;
      mag_r   <= 1'b0;
      dm_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      half_r  <= half_nxt;
      mag_r   <= mag_nxt;
      dm_r    <= dm_nxt;
    end
  end

  // Lag remainder, started with the half-length of the completed frame
  dcp_lag_mod u_lag_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (frame_done),
    .dividend  (lag_r),
    .divisor   (n_eff >> 1),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Map the result position to its two store entries
  logic [CW-1:0]     idx_i;
  logic [CW-1:0]     idx_j;
  logic              pos_zero;
  dcp_pkg::dcp_tag_t tag0;
  dcp_pkg::dcp_tag_t tag1_r;

  always_comb begin
    pos_zero = 1'b0;
    idx_i    = k_r;
    if (!mag_r) begin
      if (k_r < half_r) begin
        idx_i = k_r;
      end else if (k_r >= n_r - half_r) begin
        // mirrored half: same value as position n-1-k
        idx_i = n_r - 1'b1 - k_r;
      end else begin
        // middle of an odd frame
        idx_i    = '0;
        pos_zero = 1'b1;
      end
    end
    idx_j = idx_i;
    if (!mag_r) begin
      idx_j = idx_i + dm_r;
      if (idx_j >= half_r) begin
        idx_j = idx_j - half_r;
      end
    end
  end

  always_comb begin
    tag0.valid = issue;
    tag0.zero  = pos_zero;
    tag0.last  = (k_r == n_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (advance) begin
      tag1_r <= tag0;
    end
  end

  // Sample store
  logic                       wr_en;
  logic [dcp_pkg::WORD_W-1:0] wr_word;
  logic [dcp_pkg::WORD_W-1:0] word_a;
  logic [dcp_pkg::WORD_W-1:0] word_b;
  logic signed [SB-1:0]       smp_re;
  logic signed [SB-1:0]       smp_im;

  assign smp_re  = dcp_pkg::sample_of(in_tdata[15:0]);
  assign smp_im  = dcp_pkg::sample_of(in_tdata[31:16]);
  assign wr_word = {smp_im, smp_re};
  assign wr_en   = in_acc && (cnt_r < CW'(dcp_pkg::MAX_FRAME));

  dcp_sample_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r[dcp_pkg::ADDR_W-1:0]),
    .wr_data   (wr_word),
    .rd_en     (advance),
    .rd_addr_a (idx_j[dcp_pkg::ADDR_W-1:0]),
    .rd_addr_b (idx_i[dcp_pkg::ADDR_W-1:0]),
    .rd_data_a (word_a),
    .rd_data_b (word_b)
  );

  // Products, saturation and the output register
  logic [dcp_pkg::OUT_W-1:0] res_re;
  logic [dcp_pkg::OUT_W-1:0] res_im;

  dcp_cmul u_cmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .tag_in    (tag1_r),
    .word_a    (word_a),
    .word_b    (word_b),
    .res_valid (out_tvalid),
    .res_re    (res_re),
    .res_im    (res_im),
    .res_last  (out_tlast)
  );

  assign out_tdata = {res_im, res_re};

endmodule

FILE: hw/rtl/dcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_checker - port-level checks
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
module dcp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [63:0]                  out_tdata,
  input logic                         out_tlast,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [dcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [dcp_pkg::LEN_W-1:0]    cfg_data
);

  logic mag_mode_r;

  // track squared-magnitude mode from the register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == dcp_pkg::CFG_LAG) begin
      mag_mode_r <= (cfg_data[dcp_pkg::LAG_W-1:0] == '0);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // loading stops only on a taken sample
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("in_tready dropped without a sample taken");

  // a completed frame does not reopen loading at once
  a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_tready) |=> !in_tready)
    else $error("in_tready reopened too early");

  // squared magnitude: real part non-negative, imaginary part zero
  a_mag_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mag_mode_r |-> out_tdata[63:32] == 32'd0 && !out_tdata[31])
    else $error("squared-magnitude result malformed");

endmodule

bind differential_conj_product_core dcp_checker u_dcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);
